[rtl/core/rgb_convolution_3x3_unit_assert.svh]
`ifndef RGB_CONVOLUTION_3X3_UNIT_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_UNIT_ASSERT_SVH

// same-cycle implication, checked at every clock once out of reset
`define RGBCONV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBCONV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rgbconv_pkg.sv]
package rgbconv_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_FRAC_DEF = 8;

  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int PIX_W      = NCH * CH_W;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int ROW_W      = FH_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_ROW_W;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

  localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0]       FRAME_HEIGHT_RST = 16'd480;
  localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST     = 48'h0000_0000_0000;
  localparam logic [COEF_ROW_W-1:0] COEF_MIDDLE_RST  = 48'h0000_0100_0000;
  localparam logic [COEF_ROW_W-1:0] COEF_BOTTOM_RST  = 48'h0000_0000_0000;

  typedef logic [PIX_W-1:0] rgbconv_pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] rgbconv_win_t;
  typedef logic [2:0][COEF_ROW_W-1:0] rgbconv_coef_t;

  typedef struct packed {
    logic pass;
    logic last;
  } rgbconv_ctl_t;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgbconv_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            last_in_frame;
  } rgbconv_out_t;

endpackage

[rtl/core/rgb_convolution_3x3_unit.sv]
// 3x3 convolution of a 24-bit RGB pixel stream in raster order, one signed
// Q8.8 mask applied to blue, green and red separately; each sum is truncated
// and clamped to 0..255, and pixels on the frame border pass through as they
// came. The block takes one word per clock as long as the result side keeps
// up: the two previous rows sit in one 48-bit wide line RAM that is read when
// a word is taken and written back as that word leaves the input register, so
// the column address never repeats between read and write. The result for
// pixel k leaves with the handling of word k + frame_width + 1, through a
// 27-way multiply stage, a row-sum stage and the output register.
// After the last pixel of a frame send frame_width + 1 flush words to drain
// it; last_in_frame marks the final result. Width and height are latched at
// the first pixel of a frame; write configuration only while the block idles.
`include "rgb_convolution_3x3_unit_assert.svh"

module rgb_convolution_3x3_unit #(
  parameter int MAX_WIDTH      = rgbconv_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = rgbconv_pkg::COEF_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  rgbconv_pkg::rgbconv_in_t               in_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rgbconv_pkg::rgbconv_out_t              out_word,
  input  logic                                   cfg_we,
  input  logic [rgbconv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbconv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rgbconv_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > FW_W) ? WW : FW_W;

  logic [FW_W-1:0]       frame_width_r;
  logic [FH_W-1:0]       frame_height_r;
  logic [COEF_ROW_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  rgbconv_coef_t         coef_all;

  logic [AW-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW-1:0]   act_w_r, eff_w, fw_clamp, col_inc;
  logic [FH_W-1:0] act_h_r, eff_h, fh_clamp;
  logic [CMPW-1:0] fw_ext;
  logic [ROW_W-1:0] eff_h_x;

  logic accept, s0_start, s0_ignore, s0_end, s0_memop, s0_edge, s0_win, s0_res;
  logic s0_pass, s0_drain;
  rgbconv_pix_t s0_px;

  logic          s1_v_r, s1_memop_r, s1_res_r, s1_go, ready1;
  rgbconv_pix_t  s1_px_r;
  logic [AW-1:0] s1_col_r;
  rgbconv_ctl_t  s1_ctl_r;

  logic [LINE_W-1:0] rd_data;
  logic              mem_we, rd_en;
  rgbconv_pix_t      rd_upper, rd_lower;

  rgbconv_win_t taps_r, taps_nxt;

  logic          s2_v_r, s2_ready, mac_ready;
  rgbconv_win_t  s2_win_r;
  rgbconv_pix_t  s2_pix_r;
  rgbconv_ctl_t  s2_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      coef_top_r     <= COEF_TOP_RST;
      coef_mid_r     <= COEF_MIDDLE_RST;
      coef_bot_r     <= COEF_BOTTOM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        REG_COEF_TOP:     coef_top_r     <= cfg_wdata[COEF_ROW_W-1:0];
        REG_COEF_MIDDLE:  coef_mid_r     <= cfg_wdata[COEF_ROW_W-1:0];
        REG_COEF_BOTTOM:  coef_bot_r     <= cfg_wdata[COEF_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef_all[0] = coef_top_r;
    coef_all[1] = coef_mid_r;
    coef_all[2] = coef_bot_r;
  end

  assign fw_ext = CMPW'(frame_width_r);

  always_comb begin
    if (fw_ext < CMPW'(MIN_DIM)) begin
      fw_clamp = WW'(MIN_DIM);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      fw_clamp = WW'(MAX_WIDTH);
    end else begin
      fw_clamp = WW'(fw_ext);
    end
    fh_clamp = (frame_height_r < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_r;
  end

  always_comb begin
    s0_start  = (row_r == '0) && (col_r == '0);
    eff_w     = s0_start ? fw_clamp : act_w_r;
    eff_h     = s0_start ? fh_clamp : act_h_r;
    eff_h_x   = ROW_W'(eff_h);
    s0_ignore = in_word.command && (row_r < eff_h_x);
    s0_drain  = (row_r >= eff_h_x);
    s0_end    = (row_r == eff_h_x + ROW_W'(1));
    s0_memop  = !s0_ignore && !s0_end;
    s0_edge   = (col_r == '0) && (row_r >= ROW_W'(2));
    s0_win    = (col_r != '0) && (row_r != '0) && s0_memop;
    s0_res    = s0_edge || s0_win;
    s0_pass   = s0_edge || (row_r == ROW_W'(1)) || (row_r == eff_h_x) ||
                (col_r == AW'(1));
    s0_px     = s0_drain ? '0 : {in_word.red, in_word.green, in_word.blue};
    col_inc   = WW'(col_r) + WW'(1);
    if (s0_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc == eff_w) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
    end
  end

  assign s1_go    = s1_v_r && (!s1_res_r || s2_ready);
  assign ready1   = !s1_v_r || s1_go;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;
  assign rd_en    = accept && s0_memop;
  assign mem_we   = s1_go && s1_memop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      act_w_r <= WW'(MIN_DIM);
      act_h_r <= FH_W'(MIN_DIM);
    end else if (accept && !s0_ignore) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (s0_start) begin
        act_w_r <= fw_clamp;
        act_h_r <= fh_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ready1) begin
      s1_v_r <= accept && !s0_ignore;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r       <= s0_px;
      s1_col_r      <= col_r;
      s1_memop_r    <= s0_memop;
      s1_res_r      <= s0_res;
      s1_ctl_r.pass <= s0_pass;
      s1_ctl_r.last <= s0_end;
    end
  end

  rgbconv_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (s1_col_r),
    .wr_data ({rd_lower, s1_px_r}),
    .rd_en   (rd_en),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  assign rd_upper = rd_data[LINE_W-1:PIX_W];
  assign rd_lower = rd_data[PIX_W-1:0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      taps_nxt[r][0] = taps_r[r][1];
      taps_nxt[r][1] = taps_r[r][2];
    end
    taps_nxt[0][2] = rd_upper;
    taps_nxt[1][2] = rd_lower;
    taps_nxt[2][2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= '0;
    end else if (mem_we) begin
      taps_r <= taps_nxt;
    end
  end

  assign s2_ready = !s2_v_r || mac_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_go && s1_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_res_r) begin
      s2_win_r <= taps_nxt;
      s2_pix_r <= taps_r[1][2];
      s2_ctl_r <= s1_ctl_r;
    end
  end

  rgbconv_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s2_v_r),
    .in_ready    (mac_ready),
    .in_win      (s2_win_r),
    .in_pass_pix (s2_pix_r),
    .in_ctl      (s2_ctl_r),
    .coef        (coef_all),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  `RGBCONV_ASSERT_NOW(a_col_in_row, 1'b1, WW'(col_r) < act_w_r, "column beyond row width")
  `RGBCONV_ASSERT_NOW(a_row_bound, 1'b1, row_r <= ROW_W'(act_h_r) + ROW_W'(1), "row beyond drain")
  `RGBCONV_ASSERT_NOW(a_rmw_apart, mem_we && rd_en, s1_col_r != col_r, "line RAM read hits pending write")
  `RGBCONV_ASSERT_NEXT(a_end_rewind, accept && s0_end, (row_r == '0) && (col_r == '0), "frame end did not rewind")

endmodule

[rtl/core/rgbconv_line_mem.sv]
module rgbconv_line_mem #(
  parameter int DEPTH = rgbconv_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic [rgbconv_pkg::LINE_W-1:0]      wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic [rgbconv_pkg::LINE_W-1:0]      rd_data
);
  import rgbconv_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/rgbconv_mac.sv]
module rgbconv_mac #(
  parameter int COEF_FRAC_BITS = rgbconv_pkg::COEF_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rgbconv_pkg::rgbconv_win_t   in_win,
  input  rgbconv_pkg::rgbconv_pix_t   in_pass_pix,
  input  rgbconv_pkg::rgbconv_ctl_t   in_ctl,
  input  rgbconv_pkg::rgbconv_coef_t  coef,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rgbconv_pkg::rgbconv_out_t   out_word
);
  import rgbconv_pkg::*;

  localparam int PROD_W = CH_W + 1 + COEF_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int TOT_W  = RSUM_W + 2;

  logic signed [PROD_W-1:0] prod_r   [NCH][3][3];
  logic signed [PROD_W-1:0] prod_nxt [NCH][3][3];
  logic signed [RSUM_W-1:0] rsum_r   [NCH][3];
  logic signed [RSUM_W-1:0] rsum_nxt [NCH][3];
  logic signed [TOT_W-1:0]  tot      [NCH];
  logic        [TOT_W-1:0]  shv      [NCH];
  logic        [CH_W-1:0]   chan_res [NCH];

  logic          p_v_r, q_v_r, o_v_r;
  rgbconv_pix_t  p_pix_r, q_pix_r;
  rgbconv_ctl_t  p_ctl_r, q_ctl_r;
  rgbconv_out_t  out_word_r, out_nxt;
  logic          ready_p, ready_q, ready_o;

  assign ready_o  = !o_v_r || !out_stall;
  assign ready_q  = !q_v_r || ready_o;
  assign ready_p  = !p_v_r || ready_q;
  assign in_ready = ready_p;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_nxt[ch][r][c] =
            PROD_W'($signed({1'b0, in_win[r][c][CH_W*ch +: CH_W]})) *
            PROD_W'($signed(coef[r][COEF_W*c +: COEF_W]));
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_nxt[ch][r] = RSUM_W'(prod_r[ch][r][0]) + RSUM_W'(prod_r[ch][r][1]) +
                          RSUM_W'(prod_r[ch][r][2]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      tot[ch] = TOT_W'(rsum_r[ch][0]) + TOT_W'(rsum_r[ch][1]) + TOT_W'(rsum_r[ch][2]);
      shv[ch] = tot[ch] >> COEF_FRAC_BITS;
      if (tot[ch][TOT_W-1] || (tot[ch] == '0)) begin
        chan_res[ch] = '0;
      end else if (|shv[ch][TOT_W-1:CH_W]) begin
        chan_res[ch] = '1;
      end else begin
        chan_res[ch] = shv[ch][CH_W-1:0];
      end
    end
    if (q_ctl_r.pass) begin
      out_nxt.out_blue  = q_pix_r[0 +: CH_W];
      out_nxt.out_green = q_pix_r[CH_W +: CH_W];
      out_nxt.out_red   = q_pix_r[2*CH_W +: CH_W];
    end else begin
      out_nxt.out_blue  = chan_res[0];
      out_nxt.out_green = chan_res[1];
      out_nxt.out_red   = chan_res[2];
    end
    out_nxt.last_in_frame = q_ctl_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      q_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (ready_p) begin
        p_v_r <= in_valid;
      end
      if (ready_q) begin
        q_v_r <= p_v_r;
      end
      if (ready_o) begin
        o_v_r <= q_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_p && in_valid) begin
      prod_r  <= prod_nxt;
      p_pix_r <= in_pass_pix;
      p_ctl_r <= in_ctl;
    end
    if (ready_q && p_v_r) begin
      rsum_r  <= rsum_nxt;
      q_pix_r <= p_pix_r;
      q_ctl_r <= p_ctl_r;
    end
    if (ready_o && q_v_r) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_word  = out_word_r;

endmodule
